// File: rtl/core/prqe_pkg.sv
package prqe_pkg;

  localparam int unsigned CoordBitsDef   = 24;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned HwBits         = 16;
  localparam int unsigned TexBits        = 16;
  localparam logic [16:0] Kinv           = 17'd39797;
  localparam int unsigned NumVerts       = 12;
  localparam int unsigned VertIdxBits    = 4;

  // Map emit position to corner index (first, second, seventh, eighth repeat).
  function automatic logic [2:0] corner_of(input logic [VertIdxBits-1:0] k);
    logic [2:0] r;
    begin
      case (k)
        4'd8:    r = 3'd0;
        4'd9:    r = 3'd1;
        4'd10:   r = 3'd6;
        4'd11:   r = 3'd7;
        default: r = k[2:0];
      endcase
      return r;
    end
  endfunction

  // Command from controller to datapath.
  typedef struct packed {
    logic load;      // capture input word, prepare direction
    logic store;     // chain start: capture only as previous point
    logic norm;      // one normalization shift step
    logic vec;       // one vectoring step
    logic rot;       // one rotation step
    logic fin;       // apply sign, compute texture quarters
    logic emit;      // compute vertex into output register
    logic commit;    // move current point into previous
  } prqe_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic zero_len;
  } prqe_sts_t;

endpackage

// File: rtl/core/prqe_if.sv
interface prqe_in_if #(
  parameter int unsigned CoordBits = prqe_pkg::CoordBitsDef
);
  logic                       valid;
  logic                       ready;
  logic                       chain_start;
  logic signed [CoordBits-1:0] pos_x;
  logic signed [CoordBits-1:0] pos_y;
  logic [15:0]                half_width;
  logic [15:0]                tex_u0;
  logic [15:0]                tex_v0;
  logic [15:0]                tex_u1;
  logic [15:0]                tex_v1;
  modport source (output valid, chain_start, pos_x, pos_y, half_width,
                  tex_u0, tex_v0, tex_u1, tex_v1, input ready);
  modport sink   (input valid, chain_start, pos_x, pos_y, half_width,
                  tex_u0, tex_v0, tex_u1, tex_v1, output ready);
endinterface

interface prqe_out_if #(
  parameter int unsigned CoordBits = prqe_pkg::CoordBitsDef
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] vert_x;
  logic signed [CoordBits-1:0] vert_y;
  logic [15:0]                 tex_u;
  logic [15:0]                 tex_v;
  logic                        use_end_color;
  logic                        last_vertex;
  modport source (output valid, vert_x, vert_y, tex_u, tex_v, use_end_color,
                  last_vertex, input ready);
  modport sink   (input valid, vert_x, vert_y, tex_u, tex_v, use_end_color,
                  last_vertex, output ready);
endinterface

// File: rtl/core/polyline_ribbon_quad_expander_top.sv
// Polyline ribbon quad expander.
// in_i takes chain points (position, half width, texture rectangle); out_o
// gives ribbon vertices, twelve per segment, last_vertex on the twelfth.
// A point with chain_start set, or the first point after reset, is stored as
// the previous point and emits nothing.
// Any other point forms a segment with the stored one. The unit direction
// comes from a shared CORDIC stage iterated one step per cycle: normalize
// shifts, CordicSteps vectoring and CordicSteps rotation steps (both skipped
// for a zero-length segment), then a finish step. Each vertex is then
// computed into the output register and held there until taken; the next
// vertex is computed only after that.
// One point is in flight at a time; in_i.ready is high only when idle.
// When out_o.ready is low the vertex holds in the output register and the
// sequencer waits. Reset clears the previous-point state and the sequencer.
module polyline_ribbon_quad_expander_top #(
  parameter int unsigned CoordBits   = prqe_pkg::CoordBitsDef,
  parameter int unsigned CordicSteps = prqe_pkg::CordicStepsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  prqe_in_if.sink    in_i,
  prqe_out_if.source out_o
);
  import prqe_pkg::*;

  prqe_cmd_t cmd;
  prqe_sts_t sts;
  logic [3:0] vidx;
  logic [$clog2(CordicSteps)-1:0] step;

  prqe_ctrl #(.CordicSteps(CordicSteps)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_start_i  (in_i.chain_start),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_last_o  (out_o.last_vertex),
    .vert_idx_o  (vidx),
    .step_o      (step),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  prqe_dp #(.CoordBits(CoordBits), .CordicSteps(CordicSteps)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .step_i          (step),
    .vert_idx_i      (vidx),
    .pos_x_i         (in_i.pos_x),
    .pos_y_i         (in_i.pos_y),
    .half_width_i    (in_i.half_width),
    .rect_i          ({in_i.tex_v1, in_i.tex_u1, in_i.tex_v0, in_i.tex_u0}),
    .vert_x_o        (out_o.vert_x),
    .vert_y_o        (out_o.vert_y),
    .tex_u_o         (out_o.tex_u),
    .tex_v_o         (out_o.tex_v),
    .use_end_color_o (out_o.use_end_color)
  );

  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid)) else $error("input open while word pending");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && out_o.last_vertex |=> in_i.ready)
    else $error("segment did not end after last word");

  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd)) else $error("overlapping datapath commands");

endmodule

// File: rtl/core/prqe_ctrl.sv
module prqe_ctrl #(
  parameter int unsigned CordicSteps = prqe_pkg::CordicStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_start_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                out_last_o,
  output logic [3:0]          vert_idx_o,
  output logic [$clog2(CordicSteps)-1:0] step_o,
  output prqe_pkg::prqe_cmd_t cmd_o,
  input  prqe_pkg::prqe_sts_t sts_i
);
  import prqe_pkg::*;

  localparam int unsigned StepBits = $clog2(CordicSteps);
  localparam logic [StepBits-1:0] LastStep = StepBits'(CordicSteps - 1);

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StNorm = 7'b0000010,
    StVec  = 7'b0000100,
    StRot  = 7'b0001000,
    StFin  = 7'b0010000,
    StCalc = 7'b0100000,
    StOut  = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  logic [StepBits-1:0]   step_q, step_d;
  logic [3:0]            vidx_q, vidx_d;
  logic                  have_prev_q, have_prev_d;
  logic                  accept;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign out_last_o  = (vidx_q == 4'(NumVerts - 1));
  assign vert_idx_o  = vidx_q;
  assign step_o      = step_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    vidx_d      = vidx_q;
    have_prev_d = have_prev_q;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          have_prev_d = 1'b1;
          if (in_start_i || !have_prev_q) begin
            cmd_o.store = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            step_d     = '0;
            vidx_d     = '0;
            state_d    = StNorm;
          end
        end
      end
      StNorm: begin
        if (sts_i.zero_len) begin
          state_d = StFin;
        end else if (sts_i.norm_done) begin
          state_d = StVec;
        end else begin
          cmd_o.norm = 1'b1;
        end
      end
      StVec: begin
        cmd_o.vec = 1'b1;
        step_d    = step_q + 1'b1;
        if (step_q == LastStep) begin
          step_d  = '0;
          state_d = StRot;
        end
      end
      StRot: begin
        cmd_o.rot = 1'b1;
        step_d    = step_q + 1'b1;
        if (step_q == LastStep) begin
          step_d  = '0;
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.fin = 1'b1;
        state_d   = StCalc;
      end
      StCalc: begin
        cmd_o.emit = 1'b1;
        state_d    = StOut;
      end
      StOut: begin
        if (out_ready_i) begin
          if (out_last_o) begin
            cmd_o.commit = 1'b1;
            state_d      = StIdle;
          end else begin
            vidx_d  = vidx_q + 1'b1;
            state_d = StCalc;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      vidx_q      <= '0;
      have_prev_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      vidx_q      <= vidx_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule

// File: rtl/core/prqe_dp.sv
module prqe_dp #(
  parameter int unsigned CoordBits   = prqe_pkg::CoordBitsDef,
  parameter int unsigned CordicSteps = prqe_pkg::CordicStepsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  prqe_pkg::prqe_cmd_t         cmd_i,
  output prqe_pkg::prqe_sts_t         sts_o,
  input  logic [$clog2(CordicSteps)-1:0] step_i,
  input  logic [3:0]                  vert_idx_i,
  input  logic signed [CoordBits-1:0] pos_x_i,
  input  logic signed [CoordBits-1:0] pos_y_i,
  input  logic [15:0]                 half_width_i,
  input  logic [63:0]                 rect_i,
  output logic signed [CoordBits-1:0] vert_x_o,
  output logic signed [CoordBits-1:0] vert_y_o,
  output logic [15:0]                 tex_u_o,
  output logic [15:0]                 tex_v_o,
  output logic                        use_end_color_o
);
  import prqe_pkg::*;

  localparam int unsigned StepBits = $clog2(CordicSteps);
  // difference needs CoordBits+1; normalized magnitude stays below 2^(CoordBits+1)
  localparam int unsigned DBits = CoordBits + 1;
  localparam int unsigned CBits = CoordBits + 4;
  localparam int unsigned UBits = 19;
  localparam int unsigned PBits = 36;
  localparam int unsigned SBits = CoordBits + 2;

  // previous point A and current point B
  logic signed [CoordBits-1:0] ax_q, ay_q, bx_q, by_q;
  logic [15:0]                 aw_q, bw_q;
  logic [63:0]                 arect_q, brect_q;
  logic signed [CBits-1:0]     cx_q, cy_q;
  logic                        neg_q, zero_q;
  logic [CordicSteps-1:0]      cw_q;
  logic signed [UBits-1:0]     u_q, v_q;
  logic [15:0]                 q1_q, q3_q;
  logic signed [CoordBits-1:0] vx_q, vy_q;
  logic [15:0]                 tu_q, tv_q;
  logic                        end_q;

  logic signed [DBits-1:0] dx, dy;
  logic signed [CBits-1:0] lim, xs, ys;
  logic signed [UBits-1:0] us, vs;

  assign dx  = DBits'(pos_x_i) - DBits'(ax_q);
  assign dy  = DBits'(pos_y_i) - DBits'(ay_q);
  assign lim = CBits'(1) <<< CoordBits;
  assign xs  = cx_q >>> step_i;
  assign ys  = cy_q >>> step_i;
  assign us  = u_q >>> step_i;
  assign vs  = v_q >>> step_i;

  assign sts_o.zero_len  = zero_q;
  assign sts_o.norm_done = !((cx_q < lim) && (cy_q < lim) && (cy_q > -lim));

  // texture quarters
  logic signed [17:0] tdiff;
  logic signed [19:0] tdiff3;
  assign tdiff  = 18'(arect_q[63:48]) - 18'(arect_q[31:16]);
  assign tdiff3 = 20'(tdiff) + 20'(tdiff <<< 1);

  // vertex computation
  logic [2:0]               corner;
  logic                     is_b;
  logic signed [1:0]        oa, ob;
  logic signed [16:0]       w;
  logic signed [UBits-1:0]  c, s;
  logic signed [PBits-1:0]  ox_sum, oy_sum;
  logic signed [PBits-1:0]  wc, ws;
  logic signed [SBits-1:0]  ox, oy, px, py, sx, sy;
  logic signed [SBits-1:0]  hi_lim, lo_lim;

  always_comb begin
    corner = corner_of(vert_idx_i);
    is_b   = corner[2];
    unique case (corner)
      3'd0: begin oa = -2'sd1; ob = 2'sd0;  end
      3'd1: begin oa = 2'sd1;  ob = 2'sd0;  end
      3'd2: begin oa = 2'sd1;  ob = 2'sd1;  end
      3'd3: begin oa = -2'sd1; ob = 2'sd1;  end
      3'd4: begin oa = -2'sd1; ob = -2'sd1; end
      3'd5: begin oa = 2'sd1;  ob = -2'sd1; end
      3'd6: begin oa = 2'sd1;  ob = 2'sd0;  end
      default: begin oa = -2'sd1; ob = 2'sd0; end
    endcase
    w  = is_b ? $signed({1'b0, bw_q}) : $signed({1'b0, aw_q});
    c  = -v_q;
    s  = u_q;
    wc = PBits'(w) * PBits'(c);
    ws = PBits'(w) * PBits'(s);
    // x = a*c - b*s, y = a*s + b*c with a,b in {-w,0,w}
    ox_sum = ((oa < 0) ? -wc : wc);
    oy_sum = ((oa < 0) ? -ws : ws);
    if (ob > 0) begin
      ox_sum = ox_sum - ws;
      oy_sum = oy_sum + wc;
    end else if (ob < 0) begin
      ox_sum = ox_sum + ws;
      oy_sum = oy_sum - wc;
    end
    ox = SBits'((ox_sum + PBits'(32768)) >>> 16);
    oy = SBits'((oy_sum + PBits'(32768)) >>> 16);
    px = is_b ? SBits'(bx_q) : SBits'(ax_q);
    py = is_b ? SBits'(by_q) : SBits'(ay_q);
    sx = px + ox;
    sy = py + oy;
    hi_lim = (SBits'(1) <<< (CoordBits - 1)) - SBits'(1);
    lo_lim = -hi_lim - SBits'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q    <= '0;
      ay_q    <= '0;
      aw_q    <= '0;
      arect_q <= '0;
    end else if (cmd_i.store) begin
      ax_q    <= pos_x_i;
      ay_q    <= pos_y_i;
      aw_q    <= half_width_i;
      arect_q <= rect_i;
    end else if (cmd_i.commit) begin
      ax_q    <= bx_q;
      ay_q    <= by_q;
      aw_q    <= bw_q;
      arect_q <= brect_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= 1'b0;
    end else if (cmd_i.load) begin
      zero_q <= (dx == '0) && (dy == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bx_q    <= pos_x_i;
      by_q    <= pos_y_i;
      bw_q    <= half_width_i;
      brect_q <= rect_i;
      neg_q   <= dx < 0;
      cx_q    <= (dx < 0) ? -CBits'(dx) : CBits'(dx);
      cy_q    <= (dx < 0) ? -CBits'(dy) : CBits'(dy);
      u_q     <= UBits'(Kinv);
      v_q     <= '0;
    end else if (cmd_i.norm) begin
      cx_q <= cx_q <<< 1;
      cy_q <= cy_q <<< 1;
    end else if (cmd_i.vec) begin
      cw_q[step_i] <= !cy_q[CBits-1];
      if (!cy_q[CBits-1]) begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
      end else begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
      end
    end else if (cmd_i.rot) begin
      if (cw_q[step_i]) begin
        u_q <= u_q - vs;
        v_q <= v_q + us;
      end else begin
        u_q <= u_q + vs;
        v_q <= v_q - us;
      end
    end else if (cmd_i.fin) begin
      if (zero_q) begin
        u_q <= UBits'(65536);
        v_q <= '0;
      end else if (neg_q) begin
        u_q <= -u_q;
        v_q <= -v_q;
      end
      q1_q <= 16'(18'(arect_q[31:16]) + 18'(tdiff >>> 2));
      q3_q <= 16'(20'(arect_q[31:16]) + (tdiff3 >>> 2));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      vx_q  <= (sx > hi_lim) ? CoordBits'(hi_lim) :
               (sx < lo_lim) ? CoordBits'(lo_lim) : CoordBits'(sx);
      vy_q  <= (sy > hi_lim) ? CoordBits'(hi_lim) :
               (sy < lo_lim) ? CoordBits'(lo_lim) : CoordBits'(sy);
      tu_q  <= (oa < 0) ? arect_q[15:0] : arect_q[47:32];
      case (corner) inside
        3'd0, 3'd1: tv_q <= q1_q;
        3'd2, 3'd3: tv_q <= arect_q[31:16];
        3'd4, 3'd5: tv_q <= arect_q[63:48];
        default:    tv_q <= q3_q;
      endcase
      end_q <= is_b;
    end
  end

  assign vert_x_o        = vx_q;
  assign vert_y_o        = vy_q;
  assign tex_u_o         = tu_q;
  assign tex_v_o         = tv_q;
  assign use_end_color_o = end_q;

endmodule

// File: test/polyline_ribbon_quad_expander_top_tb.sv
`timescale 1ns / 100ps

module polyline_ribbon_quad_expander_top_tb;
  import prqe_pkg::*;

  localparam int unsigned CB = CoordBitsDef;
  localparam int unsigned STEPS = CordicStepsDef;
  localparam longint CycleLimit = 2000000;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic [15:0]          u;
    logic [15:0]          v;
    logic                 end_col;
    logic                 last;
  } vertex_t;

  typedef struct {
    logic                 start;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic [15:0]          w;
    logic [15:0]          u0, v0, u1, v1;
  } point_t;

  // floor shift for signed 64-bit
  function automatic longint fshr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint clamp_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (CB - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  class ribbon_scoreboard;
    bit     have_prev;
    point_t prev;
    vertex_t pending_verts[$];
    int     errors;
    int     checked;

    function void unit_dir(longint dx, longint dy, output longint ux, output longint uy);
      bit neg;
      bit cw[STEPS];
      longint x, y, u, v, lim, xs, ys;
      neg = 0;
      if (dx == 0 && dy == 0) begin
        ux = 65536; uy = 0; return;
      end
      if (dx < 0) begin
        dx = -dx; dy = -dy; neg = 1;
      end
      lim = longint'(1) <<< CB;
      while (dx < lim && dy < lim && dy > -lim) begin
        dx = dx * 2; dy = dy * 2;
      end
      x = dx; y = dy;
      for (int i = 0; i < STEPS; i++) begin
        xs = fshr(x, i); ys = fshr(y, i);
        cw[i] = (y >= 0);
        if (cw[i]) begin
          x = x + ys; y = y - xs;
        end else begin
          x = x - ys; y = y + xs;
        end
      end
      u = longint'(Kinv); v = 0;
      for (int i = 0; i < STEPS; i++) begin
        xs = fshr(u, i); ys = fshr(v, i);
        if (cw[i]) begin
          u = u - ys; v = v + xs;
        end else begin
          u = u + ys; v = v - xs;
        end
      end
      if (neg) begin
        u = -u; v = -v;
      end
      ux = u; uy = v;
    endfunction

    function void note_point(point_t p);
      longint ux, uy, c, s, diff, q1, q3, w, px, py, a, b;
      longint oa[8], ob[8];
      vertex_t corner[8];
      int order[12];
      oa = '{-1, 1, 1, -1, -1, 1, 1, -1};
      ob = '{0, 0, 1, 1, -1, -1, 0, 0};
      order = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 6, 7};
      if (p.start || !have_prev) begin
        have_prev = 1; prev = p; return;
      end
      unit_dir(longint'(p.x) - longint'(prev.x), longint'(p.y) - longint'(prev.y), ux, uy);
      c = -uy; s = ux;
      diff = longint'(prev.v1) - longint'(prev.v0);
      q1 = prev.v0 + fshr(diff, 2);
      q3 = prev.v0 + fshr(3 * diff, 2);
      for (int k = 0; k < 8; k++) begin
        w  = (k < 4) ? prev.w : p.w;
        px = (k < 4) ? prev.x : p.x;
        py = (k < 4) ? prev.y : p.y;
        a = w * oa[k]; b = w * ob[k];
        corner[k].x = CB'(clamp_coord(px + fshr(a * c - b * s + 32768, 16)));
        corner[k].y = CB'(clamp_coord(py + fshr(a * s + b * c + 32768, 16)));
        corner[k].u = (oa[k] < 0) ? prev.u0 : prev.u1;
        corner[k].end_col = (k >= 4);
        corner[k].last = 0;
      end
      corner[0].v = 16'(q1); corner[1].v = 16'(q1);
      corner[2].v = prev.v0; corner[3].v = prev.v0;
      corner[4].v = prev.v1; corner[5].v = prev.v1;
      corner[6].v = 16'(q3); corner[7].v = 16'(q3);
      for (int k = 0; k < 12; k++) begin
        vertex_t e;
        e = corner[order[k]];
        e.last = (k == 11);
        pending_verts = {pending_verts, e};
      end
      prev = p;
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t exp_v;
      if (pending_verts.size() == 0) begin
        $display("%0t: unexpected vertex x=%0d y=%0d", $time, got.x, got.y);
        errors++;
        return;
      end
      exp_v = pending_verts.pop_front();
      checked++;
      if (got.x !== exp_v.x) begin
        $display("%0t: vert_x exp %0d got %0d", $time, exp_v.x, got.x); errors++;
      end
      if (got.y !== exp_v.y) begin
        $display("%0t: vert_y exp %0d got %0d", $time, exp_v.y, got.y); errors++;
      end
      if (got.u !== exp_v.u) begin
        $display("%0t: tex_u exp %0h got %0h", $time, exp_v.u, got.u); errors++;
      end
      if (got.v !== exp_v.v) begin
        $display("%0t: tex_v exp %0h got %0h", $time, exp_v.v, got.v); errors++;
      end
      if (got.end_col !== exp_v.end_col) begin
        $display("%0t: use_end_color exp %0b got %0b", $time, exp_v.end_col, got.end_col);
        errors++;
      end
      if (got.last !== exp_v.last) begin
        $display("%0t: last_vertex exp %0b got %0b", $time, exp_v.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  prqe_in_if  #(.CoordBits(CB)) pts ();
  prqe_out_if #(.CoordBits(CB)) verts ();

  polyline_ribbon_quad_expander_top #(.CoordBits(CB), .CordicSteps(STEPS)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pts.sink),
    .out_o (verts.source)
  );

  ribbon_scoreboard sb;
  longint cycles;
  int     points_sent;
  bit     long_hold;   // receiver holds off for a long stretch
  bit     rx_quiet;    // stretch without receiver stalls

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
  end

  initial begin
    sb = new();
    cycles = 0;
    pts.valid = 0; pts.chain_start = 0; pts.pos_x = '0; pts.pos_y = '0;
    pts.half_width = '0; pts.tex_u0 = '0; pts.tex_v0 = '0; pts.tex_u1 = '0;
    pts.tex_v1 = '0;
    verts.ready = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: own stall pattern, long hold when asked, quiet stretches
  always @(posedge clk_i) begin
    if (!rst_ni) verts.ready <= 0;
    else if (long_hold) verts.ready <= 0;
    else if (rx_quiet) verts.ready <= 1;
    else verts.ready <= ((cycles % 23) < 15) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && verts.valid && verts.ready) begin
      vertex_t g;
      g.x = verts.vert_x; g.y = verts.vert_y; g.u = verts.tex_u; g.v = verts.tex_v;
      g.end_col = verts.use_end_color; g.last = verts.last_vertex;
      sb.check_vertex(g);
    end
  end

  task automatic send_point(point_t p);
    pts.valid <= 1;
    pts.chain_start <= p.start; pts.pos_x <= p.x; pts.pos_y <= p.y;
    pts.half_width <= p.w; pts.tex_u0 <= p.u0; pts.tex_v0 <= p.v0;
    pts.tex_u1 <= p.u1; pts.tex_v1 <= p.v1;
    do @(posedge clk_i); while (!pts.ready);
    sb.note_point(p);
    points_sent++;
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      pts.valid <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic point_t make_point(bit st, longint x, longint y, int w,
                                        int u0, int v0, int u1, int v1);
    point_t p;
    p.start = st; p.x = CB'(x); p.y = CB'(y); p.w = 16'(w);
    p.u0 = 16'(u0); p.v0 = 16'(v0); p.u1 = 16'(u1); p.v1 = 16'(v1);
    return p;
  endfunction

  // random point; coords mostly moderate, sometimes full range
  function automatic point_t rand_point(bit st);
    point_t p;
    p.start = st;
    if ($urandom_range(0, 4) == 0) begin
      p.x = CB'($urandom); p.y = CB'($urandom);
    end else begin
      p.x = CB'($signed($urandom_range(0, 65535)) - 32768);
      p.y = CB'($signed($urandom_range(0, 65535)) - 32768);
    end
    p.w = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047));
    p.u0 = 16'($urandom); p.v0 = 16'($urandom);
    p.u1 = 16'($urandom); p.v1 = 16'($urandom);
    return p;
  endfunction

  task automatic wait_drained();
    pts.valid <= 0;
    while (sb.pending_verts.size() != 0) @(posedge clk_i);
  endtask

  localparam longint XMax = (longint'(1) <<< (CB - 1)) - 1;
  localparam longint XMin = -(longint'(1) <<< (CB - 1));

  initial begin
    int burst;
    point_t p;
    points_sent = 0;
    long_hold = 0;
    rx_quiet = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // directed: no previous point with chain_start low, zero length, extremes
    send_point(make_point(0, 0, 0, 256, 0, 0, 65535, 65535));
    send_point(make_point(0, 0, 0, 256, 100, 200, 300, 1000));
    send_point(make_point(0, 2560, 0, 512, 0, 65535, 65535, 0));
    send_point(make_point(0, 2560, 2560, 0, 1, 2, 3, 4));
    send_point(make_point(0, -2560, 2560, 65535, 65535, 65535, 0, 0));
    send_point(make_point(0, -2560, -2560, 100, 0, 0, 0, 0));
    send_point(make_point(1, XMax, XMax, 65535, 0, 0, 65535, 65535));
    send_point(make_point(0, XMin, XMin, 65535, 0, 0, 65535, 65535));
    send_point(make_point(0, XMax, XMin, 65535, 65535, 0, 0, 65535));
    send_point(make_point(0, XMax, XMax, 65535, 12345, 54321, 4321, 9));
    send_point(make_point(0, XMin, XMax, 1, 0, 0, 0, 0));
    send_point(make_point(1, 7, -3, 3, 0, 0, 0, 0));
    send_point(make_point(0, 8, -3, 3, 0, 0, 0, 0));
    send_point(make_point(0, 8, 1000000, 40000, 0, 0, 0, 0));
    send_point(make_point(0, 8, -1000000, 40000, 0, 0, 0, 0));
    send_point(make_point(0, -1, -1000000, 0, 0, 0, 0, 0));

    // pause until all vertices are out
    wait_drained();

    // long receiver hold while the sender keeps offering
    long_hold = 1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        long_hold = 0;
      end
      begin
        for (int i = 0; i < 4; i++) send_point(rand_point(0));
      end
    join
    wait_drained();

    while (points_sent < 320) begin
      burst = $urandom_range(1, 12);
      rx_quiet = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < burst; i++) begin
        // mostly chains; occasional restarts
        p = rand_point($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 15) == 0) begin
          p.x = sb.prev.x; p.y = sb.prev.y;   // zero length segment
        end
        send_point(p);
      end
      idle_cycles($urandom_range(0, 1) ? 0 : $urandom_range(1, 60));
    end
    rx_quiet = 1;
    wait_drained();
    repeat (100) @(posedge clk_i);

    $display("Sent %0d points, checked %0d vertices (chains, zero length, saturation, stalls).",
             points_sent, sb.checked);
    if (sb.errors == 0 && sb.pending_verts.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
